@@ hdl/utf8_sanitizer_top_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 sanitizer assertion macros
// Concurrent assertion helpers used by the sanitizer datapath.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_TOP_ASSERT_SVH
`define UTF8_SANITIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define U8S_ASSERT(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) \
    else $error("u8s assertion failed");
`define U8S_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("u8s assertion failed");
`else
`define U8S_ASSERT(lbl, clk_i, rst_i, prop)
`define U8S_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)
`endif
`endif

@@ hdl/u8s_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Shared constants, command and status types, and lead byte decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package u8s_pkg;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_ONE = 3'd1;

  typedef struct packed {
    logic load;
    logic advance;
  } u8s_cmd_t;

  typedef struct packed {
    logic plan_empty;
    logic final_byte;
    logic out_free;
  } u8s_sts_t;

  function automatic logic [2:0] u8s_lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

  function automatic logic [7:0] u8s_repl_byte(input logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/utf8_sanitizer_top.sv @@
// The sanitizer takes one text byte per accepted beat and, after it, plays out the
// bytes that byte releases (none, a passed-through sequence, or EF BF BD replacements
// with or without a trailing literal), one output byte per cycle while the receiver
// keeps tready high, from a single output register. An accepted byte releases from
// 0 to 12 output bytes. A byte that is due waits while the output register still holds
// a beat and tready is low. The next input byte is taken once the last of the output
// bytes is loaded into the output register, even if it still waits there.

// ----------------------------------------------------------------------------
// UTF-8 sanitizer top level
// Repairs a UTF-8 byte stream, replacing malformed sequences with U+FFFD.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sanitizer_top
  import u8s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);

  u8s_cmd_t cmd;
  u8s_sts_t sts;

  u8s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8s_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule

`default_nettype wire

@@ hdl/u8s_ctrl.sv @@
// ----------------------------------------------------------------------------
// UTF-8 sanitizer controller
// Accepts one byte, then steps the datapath through its output plan.
// ----------------------------------------------------------------------------
`default_nettype none

module u8s_ctrl
  import u8s_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire u8s_sts_t sts,
  output u8s_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state;

  assign in_ready    = (state == ST_IDLE);
  assign cmd.load    = in_valid && (state == ST_IDLE);
  assign cmd.advance = (state == ST_EMIT) && !sts.plan_empty && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts.plan_empty || (cmd.advance && sts.final_byte)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/u8s_datapath.sv @@
// ----------------------------------------------------------------------------
// UTF-8 sanitizer datapath
// Holds the open sequence and plays out replacements and literal bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_sanitizer_top_assert.svh"

module u8s_datapath
  import u8s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire u8s_cmd_t   cmd,
  output u8s_sts_t        sts,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic [7:0] seq_bytes [4];
  logic [1:0] held_count;
  logic [2:0] needed_length;
  logic [2:0] rep_left;
  logic [1:0] phase;
  logic [2:0] lit_left;
  logic [1:0] lit_idx;
  logic       item_last;

  logic [1:0] held_count_next;
  logic [2:0] needed_length_next;
  logic [2:0] rep_load;
  logic [2:0] lit_load;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic [2:0] lead_len;
  logic [2:0] held_plus;
  logic       is_cont;
  logic [7:0] cur_byte;

  assign lead_len  = u8s_lead_len(in_byte);
  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign held_plus = {1'b0, held_count} + 3'd1;

  always_comb begin
    rep_load           = 3'd0;
    lit_load           = 3'd0;
    wr_en              = 1'b0;
    wr_idx             = 2'd0;
    held_count_next    = 2'd0;
    needed_length_next = 3'd0;
    if ((held_count == 2'd0) || !is_cont) begin
      rep_load = {1'b0, held_count};
      case (lead_len)
        LEN_ONE: begin
          wr_en    = 1'b1;
          lit_load = 3'd1;
        end
        LEN_BAD: begin
          rep_load = rep_load + 3'd1;
        end
        default: begin
          wr_en = 1'b1;
          if (in_last) begin
            rep_load = rep_load + 3'd1;
          end else begin
            held_count_next    = 2'd1;
            needed_length_next = lead_len;
          end
        end
      endcase
    end else begin
      wr_en  = 1'b1;
      wr_idx = held_count;
      if (held_plus >= needed_length) begin
        lit_load = held_plus;
      end else if (in_last) begin
        rep_load = held_plus;
      end else begin
        held_count_next    = held_plus[1:0];
        needed_length_next = needed_length;
      end
    end
  end

  assign cur_byte       = (rep_left != 3'd0) ? u8s_repl_byte(phase) : seq_bytes[lit_idx];
  assign sts.plan_empty = (rep_left == 3'd0) && (lit_left == 3'd0);
  assign sts.final_byte = ((rep_left == 3'd1) && (phase == 2'd2) && (lit_left == 3'd0))
                       || ((rep_left == 3'd0) && (lit_left == 3'd1));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && wr_en) begin
      seq_bytes[wr_idx] <= in_byte;
    end
    if (cmd.load) begin
      item_last <= in_last;
    end
    if (cmd.advance) begin
      out_byte <= cur_byte;
      out_last <= sts.final_byte && item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_length <= 3'd0;
      rep_left      <= 3'd0;
      phase         <= 2'd0;
      lit_left      <= 3'd0;
      lit_idx       <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        held_count    <= held_count_next;
        needed_length <= needed_length_next;
        rep_left      <= rep_load;
        lit_left      <= lit_load;
        phase         <= 2'd0;
        lit_idx       <= 2'd0;
      end else if (cmd.advance) begin
        if (rep_left != 3'd0) begin
          if (phase == 2'd2) begin
            phase    <= 2'd0;
            rep_left <= rep_left - 3'd1;
          end else begin
            phase <= phase + 2'd1;
          end
        end else begin
          lit_left <= lit_left - 3'd1;
          lit_idx  <= lit_idx + 2'd1;
        end
      end
      if (cmd.advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `U8S_ASSERT(a_held_below_need, clk, rst,
    (held_count == 2'd0) || ({1'b0, held_count} < needed_length))
  `U8S_ASSERT(a_plan_bounds, clk, rst, (rep_left <= 3'd4) && (lit_left <= 3'd4))
  `U8S_ASSERT(a_phase_in_repl, clk, rst, (phase == 2'd0) || (rep_left != 3'd0))
  `U8S_ASSERT(a_advance_has_work, clk, rst, !cmd.advance || !sts.plan_empty)

endmodule

`default_nettype wire

@@ tb/tb_utf8_sanitizer_top.sv @@
// ----------------------------------------------------------------------------
// UTF-8 sanitizer testbench
// Streams text strings through the sanitizer, predicts the repaired byte
// stream for each accepted input beat and compares every output beat with it,
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_sanitizer_top;
  import u8s_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } utf8_beat_t;

  // Predicts the repaired byte stream and holds the bytes still owed.
  class utf8_repair_model;
    logic [7:0]  held [3];
    int unsigned held_cnt = 0;
    int unsigned need_len = 0;
    utf8_beat_t  owed [$];
    int unsigned mismatches = 0;

    function void push_byte(logic [7:0] b);
      utf8_beat_t beat;
      beat.out_byte = b;
      beat.out_last = 1'b0;
      owed.push_back(beat);
    endfunction

    function void push_repl();
      push_byte(REPL_B0);
      push_byte(REPL_B1);
      push_byte(REPL_B2);
    endfunction

    function void flush_held();
      for (int unsigned k = 0; k < held_cnt; k++) push_repl();
      held_cnt = 0;
      need_len = 0;
    endfunction

    function void open_seq(logic [7:0] b);
      int unsigned len;
      if (b[7] == 1'b0) len = 1;
      else if (b[7:5] == 3'b110) len = 2;
      else if (b[7:4] == 4'b1110) len = 3;
      else if (b[7:3] == 5'b11110) len = 4;
      else len = 0;
      if (len == 1) begin
        push_byte(b);
      end else if (len == 0) begin
        push_repl();
      end else begin
        held[0] = b;
        held_cnt = 1;
        need_len = len;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic is_last);
      int unsigned start;
      start = owed.size();
      if (held_cnt == 0) begin
        open_seq(b);
      end else if (b[7:6] == 2'b10) begin
        if (held_cnt + 1 >= need_len) begin
          for (int unsigned k = 0; k < held_cnt; k++) push_byte(held[k]);
          push_byte(b);
          held_cnt = 0;
          need_len = 0;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        flush_held();
        open_seq(b);
      end
      if (is_last) begin
        flush_held();
        if (owed.size() > start) owed[owed.size() - 1].out_last = 1'b1;
      end
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    function void check_byte(logic [7:0] b, logic is_last);
      utf8_beat_t want;
      if (owed.size() == 0) begin
        note_mismatch($sformatf("unexpected beat data=%02h last=%0b", b, is_last));
      end else begin
        want = owed.pop_front();
        if (want.out_byte !== b || want.out_last !== is_last)
          note_mismatch($sformatf("expected data=%02h last=%0b, got data=%02h last=%0b",
                                  want.out_byte, want.out_last, b, is_last));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic       m_axis_tlast;

  utf8_repair_model model = new;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  utf8_sanitizer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between always ready, random, mostly stalled and
  // a fixed on/off rhythm.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_phase % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) model.check_byte(m_axis_tdata, m_axis_tlast);
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    model.take_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] text [$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (model.owed.size() != 0) @(posedge clk);
  endtask

  // Appends a lead byte for a sequence of len bytes and n_cont continuations.
  function automatic void add_seq(ref logic [7:0] text [$], input int unsigned len,
                                  input int unsigned n_cont);
    case (len)
      1: text.push_back(8'($urandom_range(1, 127)));
      2: text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      3: text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      default: text.push_back(8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    repeat (n_cont) text.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  initial begin
    logic [7:0] text [$];
    int unsigned len;
    int unsigned strings;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_string('{8'h41});
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_string('{8'hF0, 8'h80, 8'h80, 8'hF8});
    send_string('{8'hE2});
    send_string('{8'hF0, 8'h90});
    wait_drained();

    strings = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      text.delete();
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          7: begin
            len = $urandom_range(2, 4);
            add_seq(text, len, $urandom_range(0, len - 2));
          end
          8: text.push_back(8'($urandom_range(1, 255)));
          9: text.push_back($urandom_range(0, 1) ? 8'h80 | 8'($urandom_range(0, 63))
                                                 : 8'hF8 | 8'($urandom_range(0, 7)));
          default: begin
            len = $urandom_range(1, 4);
            add_seq(text, len, len - 1);
          end
        endcase
      end
      send_string(text);
      strings++;
      if (strings % 40 == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (model.mismatches == 0 && model.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
